// ===== rtl/spm_pkg.sv =====
// package for the single precision multiplier: field constants and stage types
package spm_pkg;

    localparam logic [31:0] QNAN_OUT = 32'h7FC00000;
    localparam logic [9:0]  BIAS     = 10'd127;
    localparam logic [7:0]  EXP_MAX  = 8'hFF;

    // special-case result kinds decided in the first stage
    typedef enum logic [1:0] {
        KIND_NORMAL = 2'd0,
        KIND_NAN    = 2'd1,
        KIND_ZERO   = 2'd2,
        KIND_INF    = 2'd3
    } kind_t;

    // stage 1 to 2: unpacked operands
    typedef struct packed {
        logic        sign;
        kind_t       kind;
        logic [9:0]  exp_sum;
        logic [23:0] man_a;
        logic [23:0] man_b;
    } st1_t;

    // stage 2 to 3: raw significand product
    typedef struct packed {
        logic        sign;
        kind_t       kind;
        logic [9:0]  exp_sum;
        logic [47:0] prod;
    } st2_t;

    // stage 3 to 4: normalized and rounded significand
    typedef struct packed {
        logic        sign;
        kind_t       kind;
        logic [9:0]  exp_fin;
        logic [22:0] frac;
    } st3_t;

endpackage

// ===== rtl/single_precision_multiplier.sv =====
// top level of the single precision multiplier pipeline
// Binary32 multiplier, round to nearest even, flush to zero on underflow, canonical
// quiet NaN on invalid. Four register stages (unpack, 24x24 multiply, normalize and
// round, range check and pack); one operand pair is accepted every cycle while the
// output is not stalled, and each result moves through the stages in that order and
// is presented from the pack stage register. Latency is set by the stage count; a
// stall of a valid result holds every stage.
module single_precision_multiplier
    import spm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // product [31:0]
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    st1_t        s1_reg, s1_next;
    st2_t        s2_reg;
    st3_t        s3_reg, s3_next;
    logic [31:0] out_reg, out_next;
    logic        advance;

    // whole pipeline moves when output is free
    assign advance  = !v4_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = v4_reg;
    assign m_tdata  = out_reg;

    // stage 1: classify and unpack
    always_comb
    begin
        logic [31:0] a, b;
        logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
        a = s_tdata[31:0];
        b = s_tdata[63:32];
        nan_a  = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
        nan_b  = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
        inf_a  = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
        inf_b  = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
        zero_a = (a[30:0] == 31'd0);
        zero_b = (b[30:0] == 31'd0);
        s1_next.sign    = a[31] ^ b[31];
        s1_next.exp_sum = {2'b00, a[30:23]} + {2'b00, b[30:23]} - BIAS;
        s1_next.man_a   = {1'b1, a[22:0]};
        s1_next.man_b   = {1'b1, b[22:0]};
        if (nan_a || nan_b)
            s1_next.kind = KIND_NAN;
        else if (zero_a || zero_b)
            s1_next.kind = (inf_a || inf_b) ? KIND_NAN : KIND_ZERO;
        else if (inf_a || inf_b)
            s1_next.kind = KIND_INF;
        else
            s1_next.kind = KIND_NORMAL;
    end

    // stage 3: normalize and round to nearest even
    always_comb
    begin
        logic [23:0] m;
        logic        g, st;
        logic [24:0] r;
        logic [9:0]  e;
        e = s2_reg.exp_sum;
        if (s2_reg.prod[47])
        begin
            m  = s2_reg.prod[47:24];
            g  = s2_reg.prod[23];
            st = (s2_reg.prod[22:0] != 23'd0);
            e  = e + 10'd1;
        end
        else
        begin
            m  = s2_reg.prod[46:23];
            g  = s2_reg.prod[22];
            st = (s2_reg.prod[21:0] != 22'd0);
        end
        r = {1'b0, m} + {24'd0, g && (st || m[0])};
        if (r[24])
        begin
            s3_next.frac = r[23:1];
            e = e + 10'd1;
        end
        else
            s3_next.frac = r[22:0];
        s3_next.exp_fin = e;
        s3_next.sign    = s2_reg.sign;
        s3_next.kind    = s2_reg.kind;
    end

    // stage 4: range check and pack
    always_comb
    begin
        logic over, under;
        over  = !s3_reg.exp_fin[9] && (s3_reg.exp_fin[8:0] >= 9'd255);
        under = s3_reg.exp_fin[9] || (s3_reg.exp_fin == 10'd0);
        unique case (s3_reg.kind)
            KIND_NAN:  out_next = QNAN_OUT;
            KIND_ZERO: out_next = {s3_reg.sign, 31'd0};
            KIND_INF:  out_next = {s3_reg.sign, EXP_MAX, 23'd0};
            default:
            begin
                if (over)
                    out_next = {s3_reg.sign, EXP_MAX, 23'd0};
                else if (under)
                    out_next = {s3_reg.sign, 31'd0};
                else
                    out_next = {s3_reg.sign, s3_reg.exp_fin[7:0], s3_reg.frac};
            end
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg         <= s1_next;
            s2_reg.sign    <= s1_reg.sign;
            s2_reg.kind    <= s1_reg.kind;
            s2_reg.exp_sum <= s1_reg.exp_sum;
            s2_reg.prod    <= s1_reg.man_a * s1_reg.man_b;
            s3_reg         <= s3_next;
            out_reg        <= out_next;
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    // a valid item in stage three moves into the output stage on an advance
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        advance && v3_reg |=> v4_reg)
        else $error("item lost between stages");
    // a nan kind always packs to canonical nan
    a_nan: assert property (@(posedge clk) disable iff (!rst_n)
        advance && v3_reg && s3_reg.kind == KIND_NAN |=> m_tdata == QNAN_OUT)
        else $error("nan not canonical");

endmodule

// ===== bench/single_precision_multiplier_tb.sv =====
// testbench for the single precision multiplier: directed and random operand pairs
`timescale 1ns / 1ps

module single_precision_multiplier_tb;
    import spm_pkg::*;

    localparam logic [31:0] SGN_FIELD  = 32'h80000000;
    localparam logic [31:0] EXPO_FIELD = 32'h7F800000;
    localparam logic [31:0] FRAC_MASK = 32'h007FFFFF;
    localparam logic [31:0] HIDDEN    = 32'h00800000;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          DRAIN_CYCLES = 12;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // operand_a [31:0], operand_b [63:32]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // product [31:0]

    logic [31:0] product_queue[$];
    int          mismatches;
    int          cycle_count;
    bit          no_idle;

    single_precision_multiplier u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // binary32 product, round to nearest even, flush to zero
    function automatic logic [31:0] fp_product(logic [31:0] x, logic [31:0] y);
        logic [31:0] sgn;
        logic        x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
        int          e;
        logic [47:0] m;
        logic [47:0] rem, half;
        int          sh;
        sgn    = (x ^ y) & SGN_FIELD;
        x_nan  = (x & EXPO_FIELD) == EXPO_FIELD && (x & FRAC_MASK) != 0;
        y_nan  = (y & EXPO_FIELD) == EXPO_FIELD && (y & FRAC_MASK) != 0;
        x_inf  = (x & EXPO_FIELD) == EXPO_FIELD && (x & FRAC_MASK) == 0;
        y_inf  = (y & EXPO_FIELD) == EXPO_FIELD && (y & FRAC_MASK) == 0;
        x_zero = (x & ~SGN_FIELD) == 0;
        y_zero = (y & ~SGN_FIELD) == 0;
        if (x_nan || y_nan)
            return QNAN_OUT;
        if (x_zero || y_zero)
            return (x_inf || y_inf) ? QNAN_OUT : sgn;
        if (x_inf || y_inf)
            return sgn | EXPO_FIELD;
        e = int'(x[30:23]) + int'(y[30:23]) - int'(BIAS);
        m = 48'((x & FRAC_MASK) | HIDDEN) * 48'((y & FRAC_MASK) | HIDDEN);
        if (m[47])
        begin
            sh = 24;
            e++;
        end
        else
            sh = 23;
        rem  = m & ((48'd1 << sh) - 48'd1);
        half = 48'd1 << (sh - 1);
        m    = m >> sh;
        if (rem > half || (rem == half && m[0]))
            m++;
        if (m[24])
        begin
            m = m >> 1;
            e++;
        end
        if (e >= 255)
            return sgn | EXPO_FIELD;
        if (e <= 0)
            return sgn;
        return sgn | (32'(e) << 23) | (m[31:0] & FRAC_MASK);
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 27);
    endfunction

    // send one operand pair and record its expected product
    task automatic send_pair(logic [31:0] a, logic [31:0] b);
        while (idle_now())
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        product_queue.push_back(fp_product(a, b));
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(9))
            0: v[30:23] = 8'hFF;
            1: v[30:23] = 8'h00;
            2: v[30:0]  = 31'h0;
            3: v[30:23] = 8'($urandom_range(1, 20));
            4: v[30:23] = 8'($urandom_range(235, 254));
            5: v[22:0]  = $urandom_range(1) ? 23'h0 : 23'h7FFFFF;
            default: v[30:23] = 8'($urandom_range(90, 165));
        endcase
        return v;
    endfunction

    // special values, extremes and rounding corners
    task automatic test_directed();
        send_pair(32'h7FC00001, 32'h3F800000);
        send_pair(32'h3F800000, 32'hFF800001);
        send_pair(32'h00000000, 32'h7F800000);
        send_pair(32'hFF800000, 32'h80000000);
        send_pair(32'h80000000, 32'h4049_0FDB);
        send_pair(32'h00000000, 32'h80000000);
        send_pair(32'hFF800000, 32'h3F800000);
        send_pair(32'h7F800000, 32'hFF800000);
        send_pair(32'h00000001, 32'h7F800000);
        send_pair(32'h00000001, 32'h3F800000);
        send_pair(32'h007FFFFF, 32'h7F000000);
        send_pair(32'h7F7FFFFF, 32'h7F7FFFFF);
        send_pair(32'h7F000000, 32'h40000000);
        send_pair(32'h00800000, 32'h00800000);
        send_pair(32'h00800000, 32'h3F000000);
        send_pair(32'h3F800001, 32'h3F800001);
        send_pair(32'h3FFFFFFF, 32'h3FFFFFFF);
        send_pair(32'h3F800001, 32'h3FFFFFFE);
        send_pair(32'h3FC00001, 32'h3FC00000);
        send_pair(32'hBF800000, 32'h3F800000);
        send_pair(32'hFFFFFFFF, 32'hFFFFFFFF);
        send_pair(32'h7F7FFFFF, 32'h3F800001);
    endtask

    // random pairs, with a long stretch of back-to-back transfers
    task automatic test_random();
        for (int i = 0; i < 700; i++)
        begin
            no_idle = (i >= 250 && i < 400);
            send_pair(rand_operand(), rand_operand());
        end
        no_idle = 1'b0;
    endtask

    // output side: random stall and product check
    always @(negedge clk)
        m_tready <= !rst_n ? 1'b0 : (no_idle || $urandom_range(99) >= 27);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (product_queue.size() == 0)
            begin
                $display("%0t: unexpected product, expected none, actual %h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                logic [31:0] want;
                want = product_queue.pop_front();
                if (m_tdata !== want)
                begin
                    $display("%0t: product mismatch, expected %h, actual %h",
                             $time, want, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    // run time limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        mismatches  = 0;
        cycle_count = 0;
        no_idle     = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random();
        s_tvalid <= 1'b0;
        while (product_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/spm_pkg.sv
rtl/single_precision_multiplier.sv
bench/single_precision_multiplier_tb.sv
